FILE: hw/rtl/free_space_health_monitor_assert.svh
// Assertion macros shared by the monitor's modules.
`ifndef FREE_SPACE_HEALTH_MONITOR_ASSERT_SVH
`define FREE_SPACE_HEALTH_MONITOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FSHM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fshm assertion failed");

// Next-cycle implication, checked outside reset.
`define FSHM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fshm assertion failed");

`endif

FILE: hw/rtl/fshm_pkg.sv
package fshm_pkg;

  localparam int NUM_POOLS_DEF = 2;

  localparam int BYTES_W    = 32;
  localparam int PCT_W      = 7;
  localparam int QUOT_W     = 7;
  localparam int PROD_W     = BYTES_W + PCT_W;
  localparam int STEP_W     = 3;
  localparam int RUN_W      = 9;
  localparam int GS_W       = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int IN_TDATA_W  = 3 * BYTES_W;
  localparam int OUT_FIELD_W = PCT_W + BYTES_W + 4;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [PCT_W-1:0]  PCT_FULL  = 7'd100;
  localparam logic [GS_W-1:0]   GUARD_DEF = 8'd3;
  localparam logic [STEP_W-1:0] STEP_TOP  = STEP_W'(QUOT_W - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LARGEST_WARN = 3'd0,
    CFG_LARGEST_CRIT = 3'd1,
    CFG_FRAG_WARN    = 3'd2,
    CFG_FRAG_CRIT    = 3'd3,
    CFG_GUARD_SAMP   = 3'd4,
    CFG_GUARD_EN     = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic div_step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_sts_t;

endpackage

FILE: hw/rtl/fshm_ctrl.sv
module fshm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output fshm_pkg::dp_cmd_t cmd,
  input  fshm_pkg::dp_sts_t sts
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_EVAL = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        // hold until the output register can take the result
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`include "free_space_health_monitor_assert.svh"

  `FSHM_ASSERT_NEXT(a_accept_to_mul, clk, rst_n, in_tvalid && in_tready, state_r == ST_MUL)
  `FSHM_ASSERT_NOW(a_commit_slot, clk, rst_n, cmd.commit, !out_valid_r || out_tready)
  `FSHM_ASSERT_NEXT(a_commit_valid, clk, rst_n, cmd.commit, out_valid_r)

endmodule

FILE: hw/rtl/fshm_dp.sv
module fshm_dp #(
  parameter int NUM_POOLS = fshm_pkg::NUM_POOLS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [fshm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fshm_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_pool,
  input  logic [fshm_pkg::BYTES_W-1:0]         in_total,
  input  logic [fshm_pkg::BYTES_W-1:0]         in_largest,
  input  logic [fshm_pkg::BYTES_W-1:0]         in_min,
  input  fshm_pkg::dp_cmd_t                    cmd,
  output fshm_pkg::dp_sts_t                    sts,
  output logic [fshm_pkg::OUT_TDATA_W-1:0]     out_data
);

  localparam int PIDX_W = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int BW     = fshm_pkg::BYTES_W;
  localparam int PW     = fshm_pkg::PCT_W;

  // configuration
  logic [BW-1:0]             lw_bytes_r, lc_bytes_r;
  logic [PW-1:0]             fw_pct_r, fc_pct_r;
  logic [fshm_pkg::GS_W-1:0] guard_samp_r;
  logic                      guard_en_r;

  // per-item working registers
  logic [PIDX_W-1:0]             pidx_r;
  logic [BW-1:0]                 total_r, largest_r, minf_r;
  logic [fshm_pkg::PROD_W-1:0]   rem_r;
  logic [fshm_pkg::QUOT_W-1:0]   quot_r;
  logic [fshm_pkg::STEP_W-1:0]   step_r;

  // pool state
  logic [BW-1:0]              low_mark_r   [NUM_POOLS];
  logic [BW-1:0]              rep_total_r  [NUM_POOLS];
  logic [BW-1:0]              rep_largest_r[NUM_POOLS];
  logic [BW-1:0]              rep_min_r    [NUM_POOLS];
  logic [BW-1:0]              rep_lm_r     [NUM_POOLS];
  logic [PW-1:0]              rep_frag_r   [NUM_POOLS];
  logic [1:0]                 rep_flags_r  [NUM_POOLS];
  logic [fshm_pkg::RUN_W-1:0] crit_run_r, crit_run_nxt;

  // output register
  logic [PW-1:0] out_frag_r;
  logic [BW-1:0] out_lw_r;
  logic          out_warn_r, out_crit_r, out_trip_r, out_chg_r;

  logic [PIDX_W-1:0]           pidx_in;
  logic [fshm_pkg::PROD_W-1:0] dsh;
  logic                        ge;
  logic [PW-1:0]               frag;
  logic [BW-1:0]               lm_cur, lm_new;
  logic                        warn, crit, changed, trip;
  logic [1:0]                  flags;
  logic [fshm_pkg::RUN_W-1:0]  run_inc, gs_ext;

  assign pidx_in = (int'(in_pool) >= NUM_POOLS) ? PIDX_W'(NUM_POOLS - 1) : PIDX_W'(in_pool);

  // restoring division step: one quotient bit, MSB first
  assign dsh = fshm_pkg::PROD_W'(total_r) << step_r;
  assign ge  = (rem_r >= dsh);
  assign sts.div_last = (step_r == '0);

  always_comb begin
    if (total_r == '0) begin
      frag = fshm_pkg::PCT_FULL;
    end else if (largest_r >= total_r) begin
      frag = '0;
    end else begin
      frag = fshm_pkg::PCT_FULL - quot_r;
    end
  end

  assign lm_cur = low_mark_r[pidx_r];
  assign lm_new = (lm_cur == '0 || largest_r < lm_cur) ? largest_r : lm_cur;

  always_comb begin
    crit = (lc_bytes_r != '0 && largest_r < lc_bytes_r) ||
           (fc_pct_r != '0 && frag >= fc_pct_r);
    warn = crit ||
           (lw_bytes_r != '0 && largest_r < lw_bytes_r) ||
           (fw_pct_r != '0 && frag >= fw_pct_r);
  end
  assign flags = {crit, warn};

  assign changed = (rep_total_r[pidx_r]   != total_r)   ||
                   (rep_largest_r[pidx_r] != largest_r) ||
                   (rep_min_r[pidx_r]     != minf_r)    ||
                   (rep_lm_r[pidx_r]      != lm_new)    ||
                   (rep_frag_r[pidx_r]    != frag)      ||
                   (rep_flags_r[pidx_r]   != flags);

  // pool-0 run of critical samples; step one past the count after a trip
  assign gs_ext  = fshm_pkg::RUN_W'(guard_samp_r);
  assign run_inc = (crit_run_r < gs_ext) ? crit_run_r + 1'b1 : crit_run_r;

  always_comb begin
    crit_run_nxt = crit_run_r;
    trip         = 1'b0;
    if (pidx_r == '0) begin
      if (guard_en_r && crit) begin
        if (run_inc == gs_ext) begin
          trip         = 1'b1;
          crit_run_nxt = run_inc + 1'b1;
        end else begin
          crit_run_nxt = run_inc;
        end
      end else begin
        crit_run_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_bytes_r   <= '0;
      lc_bytes_r   <= '0;
      fw_pct_r     <= '0;
      fc_pct_r     <= '0;
      guard_samp_r <= fshm_pkg::GUARD_DEF;
      guard_en_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        fshm_pkg::CFG_LARGEST_WARN: lw_bytes_r   <= cfg_data[BW-1:0];
        fshm_pkg::CFG_LARGEST_CRIT: lc_bytes_r   <= cfg_data[BW-1:0];
        fshm_pkg::CFG_FRAG_WARN:    fw_pct_r     <= cfg_data[PW-1:0];
        fshm_pkg::CFG_FRAG_CRIT:    fc_pct_r     <= cfg_data[PW-1:0];
        fshm_pkg::CFG_GUARD_SAMP:   guard_samp_r <= cfg_data[fshm_pkg::GS_W-1:0];
        fshm_pkg::CFG_GUARD_EN:     guard_en_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (cmd.mul) begin
      step_r <= fshm_pkg::STEP_TOP;
    end else if (cmd.div_step && step_r != '0) begin
      step_r <= step_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pidx_r    <= pidx_in;
      total_r   <= in_total;
      largest_r <= in_largest;
      minf_r    <= in_min;
    end
    if (cmd.mul) begin
      rem_r  <= fshm_pkg::PROD_W'(largest_r) * fshm_pkg::PROD_W'(fshm_pkg::PCT_FULL);
      quot_r <= '0;
    end else if (cmd.div_step) begin
      if (ge) begin
        rem_r <= rem_r - dsh;
      end
      quot_r <= {quot_r[fshm_pkg::QUOT_W-2:0], ge};
    end
    if (cmd.commit) begin
      out_frag_r <= frag;
      out_lw_r   <= lm_new;
      out_warn_r <= warn;
      out_crit_r <= crit;
      out_trip_r <= trip;
      out_chg_r  <= changed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crit_run_r <= '0;
      for (int i = 0; i < NUM_POOLS; i++) begin
        low_mark_r[i]    <= '0;
        rep_total_r[i]   <= '0;
        rep_largest_r[i] <= '0;
        rep_min_r[i]     <= '0;
        rep_lm_r[i]      <= '0;
        rep_frag_r[i]    <= '0;
        rep_flags_r[i]   <= '0;
      end
    end else if (cmd.commit) begin
      crit_run_r            <= crit_run_nxt;
      low_mark_r[pidx_r]    <= lm_new;
      rep_total_r[pidx_r]   <= total_r;
      rep_largest_r[pidx_r] <= largest_r;
      rep_min_r[pidx_r]     <= minf_r;
      rep_lm_r[pidx_r]      <= lm_new;
      rep_frag_r[pidx_r]    <= frag;
      rep_flags_r[pidx_r]   <= flags;
    end
  end

  assign out_data = fshm_pkg::OUT_TDATA_W'({out_chg_r, out_trip_r, out_crit_r, out_warn_r,
                                            out_lw_r, out_frag_r});

`include "free_space_health_monitor_assert.svh"

  `FSHM_ASSERT_NEXT(a_crit_has_warn, clk, rst_n, cmd.commit, !out_crit_r || out_warn_r)
  `FSHM_ASSERT_NEXT(a_trip_has_crit, clk, rst_n, cmd.commit, !out_trip_r || out_crit_r)
  `FSHM_ASSERT_NEXT(a_trip_pool0, clk, rst_n, cmd.commit && pidx_r != '0, !out_trip_r)

endmodule

FILE: hw/rtl/free_space_health_monitor.sv
// Channel | Dir | Handshake          | Payload
// in_     | in  | in_tvalid/tready   | tuser: pool; tdata: total, largest, min free
// out_    | out | out_tvalid/tready  | tdata: frag %, low watermark, warn, crit, trip, chg
// cfg_    | in  | cfg_valid/ready    | cfg_index: register, cfg_data: value
//
// One item at a time: after the accept edge, the multiply state forms largest*100,
// the divide state runs a restoring divider (seven quotient bits, one per step)
// and the evaluate state loads the output register. out_tvalid rises with that load
// and in_tready returns with it, so the next item is accepted only once it is loaded.
// A stalled output holds the evaluate step until the register is free. Reset
// (rst_n low, synchronous) clears pool state and restores the default config.
module free_space_health_monitor #(
  parameter int NUM_POOLS = fshm_pkg::NUM_POOLS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input item
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [95:64] lowest free ever, [63:32] largest block, [31:0] total bytes free
  input  logic [fshm_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] pool
  input  logic                                in_tuser,
  // result item
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [42] changed, [41] guard_trip, [40] crit, [39] warn,
  // [38:7] low_watermark, [6:0] frag_percent, upper bits zero
  output logic [fshm_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fshm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fshm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int BW = fshm_pkg::BYTES_W;

  fshm_pkg::dp_cmd_t cmd;
  fshm_pkg::dp_sts_t sts;

  // registers are plain flops: a write is registered at the next clock edge, always accepted
  assign cfg_ready = 1'b1;

  // sequencing: accept, multiply, divide, evaluate
  fshm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // arithmetic, thresholds, pool state and the output register
  fshm_dp #(
    .NUM_POOLS (NUM_POOLS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_pool    (in_tuser),
    .in_total   (in_tdata[BW-1:0]),
    .in_largest (in_tdata[2*BW-1:BW]),
    .in_min     (in_tdata[3*BW-1:2*BW]),
    .cmd        (cmd),
    .sts        (sts),
    .out_data   (out_tdata)
  );

endmodule
